@@ src/gnb_pkg.sv @@
// shared types and constants of the gaussian naive bayes classifier
package gnb_pkg;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_LABEL  = 2'd1;
    localparam logic [1:0] ACT_FEAT   = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    localparam logic [1:0] ADDR_CLASS_COUNT = 2'd0;

    localparam int LOG2_CELLS = 16;
    localparam int NUM_W      = 51;
    localparam int DEN_W      = 25;
    localparam int PROD_W     = 54;

    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [31:0] HALF_LN_2PI = 32'd60224;
    localparam logic signed [31:0] LN_FLOOR = -32'sd1056316;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         class_slot;
        logic [3:0]         feature_index;
        logic signed [23:0] value;
        logic [23:0]        variance;
        logic signed [7:0]  class_label;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0]  predicted_label;
        logic signed [31:0] best_score;
    } result_t;

    // one stage of the log2 squaring chain
    typedef struct packed {
        logic        valid;
        logic [30:0] y;
        logic [15:0] frac;
        logic [4:0]  e;
    } l2_stage_t;

endpackage

@@ src/gaussian_naive_bayes_classifier.sv @@
// top level of the gaussian naive bayes classifier
//
// usage: items arrive on item with start; a transfer happens when start is
// high and busy is low. load items (mean/variance, label) and classify
// items for features other than the last are stored at their transfer.
// the classify item at the last feature index starts scoring, busy stays
// high until the cycle of the result transfer, which is one cycle with
// done high. scoring runs the log of the class count, then per class
// feature term a fetch, setup, divider wait and log scaling; a zero
// variance term is skipped after its fetch; then the label is fetched
// before the done cycle. the divider, one quotient bit per cycle, sets
// the scoring time; log2 runs alongside it in a row of 16 squaring cells.
// class_count is written through the apb port; the user must write it
// only while the block is idle, the block itself does not enforce this.
// reset clears control state and sets class_count to 1; the stores hold
// nothing valid until written. the receiver cannot stall: done is a pulse.
module gaussian_naive_bayes_classifier #(
    parameter int MAX_CLASSES   = 16,
    parameter int FEATURE_COUNT = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    input  gnb_pkg::in_item_t item,
    output logic              busy,
    output logic              done,
    output gnb_pkg::result_t  result
);
    import gnb_pkg::*;

    localparam int DEPTH = MAX_CLASSES * FEATURE_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_CLASSES);
    localparam int IW    = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CW    = $clog2(MAX_CLASSES + 1);
    localparam int SW    = 40;
    localparam int TW    = 54;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LNC_W = 4'd1;
    localparam logic [3:0] S_LNC_M = 4'd2;
    localparam logic [3:0] S_LNC_R = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_DAT   = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_LNM   = 4'd9;
    localparam logic [3:0] S_TERM  = 4'd10;
    localparam logic [3:0] S_LAB   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // model stores
    logic signed [23:0] mean_mem  [DEPTH];
    logic [23:0]        var_mem   [DEPTH];
    logic [7:0]         label_mem [MAX_CLASSES];
    logic signed [23:0] feat_reg  [FEATURE_COUNT];
    logic signed [23:0] mean_rd_reg;
    logic [23:0]        var_rd_reg;
    logic [7:0]         label_rd_reg;

    logic [3:0]            state_reg, state_next;
    logic [4:0]            class_count_reg;
    logic [CW-1:0]         j_reg, j_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [AW-1:0]         k_reg, k_next;
    logic [LW-1:0]         win_reg, win_next;
    logic signed [SW-1:0]  s_reg, s_next;
    logic signed [SW-1:0]  best_reg, best_next;
    logic [23:0]           lnc_reg, lnc_next;
    logic [24:0]           mag_reg, mag_next;
    logic [23:0]           v_reg, v_next;
    logic [49:0]           sq_reg, sq_next;
    logic [NUM_W-1:0]      q_reg, q_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  neg_reg, neg_next;
    logic [20:0]           l2_reg;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    logic                  accept;
    logic                  trigger;
    logic                  load_ok;
    logic                  label_ok;
    logic [AW-1:0]         load_addr;
    logic [CW-1:0]         c_eff;
    logic                  chain_in_valid;
    logic [23:0]           chain_in_n;
    logic                  chain_out_valid;
    logic [20:0]           chain_l2;
    logic                  div_start;
    logic                  div_done;
    logic [NUM_W-1:0]      div_quo;
    logic signed [24:0]    diff;
    logic signed [21:0]    lv;
    logic [21:0]           lv_mag;
    logic [20:0]           r_half;
    logic signed [TW-1:0]  half_s;
    logic signed [TW-1:0]  t_val;
    logic signed [SW-1:0]  s_upd;
    logic                  add_term;
    logic                  advance;

    assign accept  = start && !busy;
    assign trigger = (item.action == ACT_FEAT) &&
                     (32'(item.feature_index) == FEATURE_COUNT - 1);
    assign load_ok = (item.action == ACT_LOAD) &&
                     (32'(item.class_slot) < MAX_CLASSES) &&
                     (32'(item.feature_index) < FEATURE_COUNT);
    assign label_ok = (item.action == ACT_LABEL) &&
                      (32'(item.class_slot) < MAX_CLASSES);
    assign load_addr = AW'(32'(item.class_slot) * FEATURE_COUNT +
                           32'(item.feature_index));

    // class count clamped to 1..MAX_CLASSES
    always_comb
    begin
        if (class_count_reg == 5'd0)
        begin
            c_eff = CW'(1);
        end
        else if (32'(class_count_reg) > MAX_CLASSES)
        begin
            c_eff = CW'(MAX_CLASSES);
        end
        else
        begin
            c_eff = CW'(class_count_reg);
        end
    end

    // apb register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CLASS_COUNT) ? {27'd0, class_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= 5'd1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            class_count_reg <= pwdata[4:0];
        end
    end

    // model memories, written by load transfers, read at the term pointer
    always_ff @(posedge clk)
    begin
        if (accept && load_ok)
        begin
            mean_mem[load_addr] <= item.value;
            var_mem[load_addr]  <= item.variance;
        end
        mean_rd_reg <= mean_mem[k_reg];
        var_rd_reg  <= var_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && label_ok)
        begin
            label_mem[LW'(item.class_slot)] <= item.class_label;
        end
        label_rd_reg <= label_mem[win_reg];
    end

    // feature buffer
    always_ff @(posedge clk)
    begin
        if (accept && (item.action == ACT_FEAT) &&
            (32'(item.feature_index) < FEATURE_COUNT))
        begin
            feat_reg[IW'(item.feature_index)] <= item.value;
        end
    end

    // log2 unit: class count at scoring start, then each nonzero variance
    assign chain_in_valid = (accept && trigger) || (state_reg == S_DAT && var_rd_reg != 24'd0);
    assign chain_in_n     = (state_reg == S_IDLE) ? 24'(c_eff) : var_rd_reg;

    gnb_log2_chain u_log2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_in_valid),
        .n        (chain_in_n),
        .out_valid(chain_out_valid),
        .l2       (chain_l2)
    );

    always_ff @(posedge clk)
    begin
        if (chain_out_valid)
        begin
            l2_reg <= chain_l2;
        end
    end

    // quotient of the squared distance term
    assign div_start = (state_reg == S_DIVS);

    gnb_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (NUM_W'(sq_reg) + NUM_W'(v_reg)),
        .den  ({1'b0, v_reg} << 1),
        .done (div_done),
        .quo  (div_quo)
    );

    // term arithmetic
    assign diff   = 25'(feat_reg[i_reg]) - 25'(mean_rd_reg);
    assign lv     = $signed({1'b0, l2_reg}) - 22'sd1048576;
    assign lv_mag = lv[21] ? 22'(-lv) : 22'(lv);
    assign r_half = 21'((prod_reg + (PROD_W'(1) << 32)) >> 33);
    assign half_s = neg_reg ? -$signed(TW'(r_half)) : $signed(TW'(r_half));
    assign t_val  = $signed(TW'(lnc_reg)) - $signed(TW'(HALF_LN_2PI)) - half_s
                    - $signed(TW'(q_reg));
    assign add_term = (state_reg == S_TERM) && (t_val > TW'(LN_FLOOR));
    assign s_upd    = add_term ? s_reg + SW'(t_val) : s_reg;
    assign advance  = (state_reg == S_TERM) ||
                      (state_reg == S_DAT && var_rd_reg == 24'd0);

    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        win_next    = win_reg;
        s_next      = s_reg;
        best_next   = best_reg;
        lnc_next    = lnc_reg;
        mag_next    = mag_reg;
        v_next      = v_reg;
        sq_next     = sq_reg;
        q_next      = q_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && trigger)
                begin
                    state_next = S_LNC_W;
                end
            end
            S_LNC_W:
            begin
                if (chain_out_valid)
                begin
                    state_next = S_LNC_M;
                end
            end
            S_LNC_M:
            begin
                prod_next  = PROD_W'(l2_reg) * PROD_W'(LN2_Q32);
                state_next = S_LNC_R;
            end
            S_LNC_R:
            begin
                lnc_next   = 24'((prod_reg + (PROD_W'(1) << 31)) >> 32);
                s_next     = -$signed(SW'(24'((prod_reg + (PROD_W'(1) << 31)) >> 32)));
                j_next     = '0;
                i_next     = '0;
                k_next     = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_DAT;
            end
            S_DAT:
            begin
                mag_next = diff[24] ? 25'(-diff) : 25'(diff);
                v_next   = var_rd_reg;
                if (var_rd_reg != 24'd0)
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                sq_next    = 50'(mag_reg) * 50'(mag_reg);
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    q_next     = div_quo;
                    state_next = S_LNM;
                end
            end
            S_LNM:
            begin
                prod_next  = PROD_W'(lv_mag) * PROD_W'(LN2_Q32);
                neg_next   = lv[21];
                state_next = S_TERM;
            end
            S_TERM:
            begin
                state_next = S_TERM;
            end
            S_LAB:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                done_next                   = 1'b1;
                result_next.predicted_label = label_rd_reg;
                result_next.best_score      = best_reg[31:0];
                state_next                  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // step to the next term, closing the class on its last feature
        if (advance)
        begin
            k_next = k_reg + AW'(1);
            if (i_reg == IW'(FEATURE_COUNT - 1))
            begin
                if ((j_reg == '0) || (s_upd >= best_reg))
                begin
                    best_next = s_upd;
                    win_next  = j_reg[LW-1:0];
                end
                if (j_reg == c_eff - CW'(1))
                begin
                    state_next = S_LAB;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    i_next     = '0;
                    s_next     = -$signed(SW'(lnc_reg));
                    state_next = S_RD;
                end
            end
            else
            begin
                i_next     = i_reg + IW'(1);
                s_next     = s_upd;
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        i_reg      <= i_next;
        k_reg      <= k_next;
        win_reg    <= win_next;
        s_reg      <= s_next;
        best_reg   <= best_next;
        lnc_reg    <= lnc_next;
        mag_reg    <= mag_next;
        v_reg      <= v_next;
        sq_reg     <= sq_next;
        q_reg      <= q_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
endmodule

@@ src/gnb_log2_cell.sv @@
// one squaring cell of the log2 chain, yields one fraction bit
module gnb_log2_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  gnb_pkg::l2_stage_t din,
    output gnb_pkg::l2_stage_t dout
);
    import gnb_pkg::*;

    logic [61:0] sq;
    logic [31:0] yn;
    logic        valid_reg;
    logic [30:0] y_reg;
    logic [15:0] frac_reg;
    logic [4:0]  e_reg;

    assign sq = 62'(din.y) * 62'(din.y);
    assign yn = sq[61:30];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= yn[31] ? yn[31:1] : yn[30:0];
        frac_reg <= {din.frac[14:0], yn[31]};
        e_reg    <= din.e;
    end

    assign dout.valid = valid_reg;
    assign dout.y     = y_reg;
    assign dout.frac  = frac_reg;
    assign dout.e     = e_reg;
endmodule

@@ src/gnb_log2_chain.sv @@
// log2 of a 24-bit integer in q5.16 through a row of squaring cells
module gnb_log2_chain (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [23:0] n,
    output logic        out_valid,
    output logic [20:0] l2
);
    import gnb_pkg::*;

    l2_stage_t   stage [LOG2_CELLS+1];
    logic [4:0]  msb;
    logic [54:0] shifted;

    always_comb
    begin
        msb = 5'd0;
        for (int b = 0; b < 24; b++)
        begin
            if (n[b])
            begin
                msb = 5'(b);
            end
        end
    end

    // mantissa normalized to [1,2) in q1.30
    assign shifted = (55'(n) << 30) >> msb;

    assign stage[0].valid = in_valid;
    assign stage[0].y     = shifted[30:0];
    assign stage[0].frac  = 16'd0;
    assign stage[0].e     = msb;

    for (genvar g = 0; g < LOG2_CELLS; g++)
    begin : g_cell
        gnb_log2_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (stage[g]),
            .dout (stage[g+1])
        );
    end

    assign out_valid = stage[LOG2_CELLS].valid;
    assign l2        = {stage[LOG2_CELLS].e, stage[LOG2_CELLS].frac};
endmodule

@@ src/gnb_divider.sv @@
// restoring divider, one quotient bit per cycle
module gnb_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gnb_pkg::NUM_W-1:0] num,
    input  logic [gnb_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [gnb_pkg::NUM_W-1:0] quo
);
    import gnb_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg, q_reg[NUM_W-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(NUM_W);
            q_next   = num;
            rem_next = '0;
            den_next = den;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
